[hw/rtl/skt_pkg.sv]
// shared types, defaults and result codes for the sorted key table
`timescale 1ns / 1ps

package skt_pkg;

  // default table geometry
  localparam int DEPTH_DEF     = 8;
  localparam int KEY_CHARS_DEF = 8;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // controls broadcast to every cell
  typedef struct packed {
    logic cmp_en;    // capture compare flags against the request key
    logic shift_en;  // commit an insert: keep, take the key, or take the neighbor
  } cell_ctl_t;

  // flags a cell reports to the controller and its upper neighbor
  typedef struct packed {
    logic lt;     // occupied and stored key below request key
    logic eq;     // occupied and stored key equal to request key
    logic place;  // first cell not below the request key
  } cell_flag_t;

endpackage

[hw/rtl/skt_cell.sv]
// one table slot: holds a key, compares it and shifts it up on insert
`timescale 1ns / 1ps

module skt_cell #(
  parameter int KEY_W = 8 * skt_pkg::KEY_CHARS_DEF,
  parameter int CNT_W = 4,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  skt_pkg::cell_ctl_t   ctl,
  input  logic [KEY_W-1:0]     key_in,
  input  logic [CNT_W-1:0]     count,
  input  logic [KEY_W-1:0]     prev_key,
  input  logic                 prev_lt,
  output logic [KEY_W-1:0]     key_out,
  output skt_pkg::cell_flag_t  flag
);
  import skt_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             lt_r;
  logic             eq_r;
  logic             occupied;

  assign occupied = CNT_W'(INDEX) < count;

  // compare flags, captured once per request
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= occupied && (key_r < key_in);
      eq_r <= occupied && (key_r == key_in);
    end
  end

  // insert: smaller keys stay, the sorted slot takes the key, the rest move up
  always_ff @(posedge clk) begin
    if (ctl.shift_en && !lt_r) begin
      if (prev_lt) begin
        key_r <= key_in;
      end else begin
        key_r <= prev_key;
      end
    end
  end

  assign key_out    = key_r;
  assign flag.lt    = lt_r;
  assign flag.eq    = eq_r;
  assign flag.place = !lt_r && prev_lt;

endmodule

[hw/rtl/sorted_key_table.sv]
// sorted key table: ordered key store with insert and search requests
// each request runs a compare step, then a shift-and-write step; a new request is
// accepted only as the previous one commits, and an unread result stalls the commit
// the cell row registers its compare flags before the shift that uses them
// reset: entry count and handshake control clear, key cells hold garbage until written
`timescale 1ns / 1ps

module sorted_key_table #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEF,
  parameter int KEY_CHARS = skt_pkg::KEY_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_position,
  output logic [3:0]  out_entry_count
);
  import skt_pkg::*;

  localparam int KEY_W = 8 * KEY_CHARS;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = (IDX_W > 3) ? IDX_W : 3;
  localparam int OCW   = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CMP    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [KEY_W-1:0] key_r;
  logic             mode_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [2:0]       status_r;
  logic [2:0]       position_r;
  logic [3:0]       entry_count_r;

  logic             in_acc;
  logic             commit_go;
  logic             present;
  logic             full;
  logic             inserting;
  logic [POS_W-1:0] pos_wide;
  logic [2:0]       status_nxt;
  logic [2:0]       position_nxt;
  logic [OCW-1:0]   count_wide;

  cell_ctl_t        ctl;
  cell_flag_t       flag   [DEPTH];
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] place_vec;

  // handshake
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE) || commit_go;
  assign in_acc    = in_valid && in_ready;

  // cell row controls
  assign ctl.cmp_en   = (state_r == S_CMP);
  assign ctl.shift_en = commit_go && inserting;

  // row of cells, each fed by its lower neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] pk;
    logic             pl;
    if (i == 0) begin : g_first
      assign pk = key_r;
      assign pl = 1'b1;
    end else begin : g_rest
      assign pk = cell_key[i-1];
      assign pl = flag[i-1].lt;
    end
    skt_cell #(
      .KEY_W(KEY_W),
      .CNT_W(CNT_W),
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_in   (key_r),
      .count    (count_r),
      .prev_key (pk),
      .prev_lt  (pl),
      .key_out  (cell_key[i]),
      .flag     (flag[i])
    );
    assign eq_vec[i]    = flag[i].eq;
    assign place_vec[i] = flag[i].place;
  end

  // position of the sorted slot from the one-hot place flags
  always_comb begin
    pos_wide = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (place_vec[i]) begin
        pos_wide = pos_wide | POS_W'(i);
      end
    end
  end

  // result decode
  assign present   = |eq_vec;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign inserting = !mode_r && !present && !full;

  always_comb begin
    status_nxt   = ST_NOT_FOUND;
    position_nxt = 3'd0;
    if (mode_r) begin
      if (present) begin
        status_nxt   = ST_FOUND;
        position_nxt = pos_wide[2:0];
      end
    end else if (present) begin
      status_nxt   = ST_DUPLICATE;
      position_nxt = pos_wide[2:0];
    end else if (full) begin
      status_nxt   = ST_FULL;
    end else begin
      status_nxt   = ST_INSERTED;
      position_nxt = pos_wide[2:0];
    end
  end

  assign count_nxt  = inserting ? count_r + CNT_W'(1) : count_r;
  assign count_wide = OCW'(count_nxt);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_go) state_nxt = in_acc ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= in_key[63 -: KEY_W];
      mode_r <= in_mode;
    end
    if (commit_go) begin
      status_r      <= status_nxt;
      position_r    <= position_nxt;
      entry_count_r <= count_wide[3:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;

  // count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // at most one sorted slot and at most one matching cell
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> ($onehot0(place_vec) && $onehot0(eq_vec)))
    else $error("cell flags not one-hot");

  // a matching key sits in the sorted slot
  a_hit_at_place: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && present) |-> ((eq_vec & place_vec) == eq_vec))
    else $error("match outside sorted slot");

  // a committed insert grows the table by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && inserting) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not bump count");

endmodule
